@@ design/sccb_master_bit_sequencer_assert.svh @@
// Assertion macros for the two-wire bus master bit sequencer.
// Included by the top level; needs nothing else.
`ifndef SCCB_MASTER_BIT_SEQUENCER_ASSERT_SVH
`define SCCB_MASTER_BIT_SEQUENCER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/sbs_pkg.sv @@
// Shared types and constants of the two-wire bus master bit sequencer.
// Used by sbs_step and the top level; depends on nothing.
package sbs_pkg;

  localparam int HP_W = 10;

  localparam logic [HP_W-1:0] HALF_PERIOD_RST = 10'd50;
  localparam logic [HP_W-1:0] TAIL_TICKS      = 10'd2;
  localparam logic [HP_W-1:0] RELEASE_TICKS   = 10'd10;
  localparam logic [HP_W-1:0] ACK_HIGH_TICKS  = 10'd80;

  localparam logic [2:0] CMD_IDLE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;
  localparam logic [2:0] CMD_NOACK = 3'd5;

  typedef struct packed {
    logic [2:0]      cmd;
    logic [2:0]      phase;
    logic [2:0]      bit_idx;
    logic [HP_W-1:0] wait_cnt;
    logic [7:0]      shift;
    logic            clk_lvl;
    logic            dat_lvl;
    logic            dat_drv;
    logic            ack;
    logic [7:0]      rd_byte;
  } sbs_state_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       busy;
    logic       done;
    logic       ack_ok;
    logic [7:0] read_data;
  } sbs_res_t;

  localparam sbs_state_t STATE_RST = '{
    cmd: CMD_IDLE, phase: 3'd0, bit_idx: 3'd0, wait_cnt: '0, shift: 8'd0,
    clk_lvl: 1'b1, dat_lvl: 1'b1, dat_drv: 1'b1, ack: 1'b0, rd_byte: 8'd0
  };

endpackage

@@ design/sbs_step.sv @@
// One tick of the bus sequencer: next state and result from the current state.
// Purely combinational; depends on sbs_pkg.
module sbs_step (
  input  sbs_pkg::sbs_state_t         cur,
  input  logic [sbs_pkg::HP_W-1:0]    half_period,
  input  logic [2:0]                  opcode,
  input  logic [7:0]                  write_data,
  input  logic                        sda_in,
  output sbs_pkg::sbs_state_t         nxt,
  output sbs_pkg::sbs_res_t           res
);
  import sbs_pkg::*;

  // Drive the lines for the phase that begins and load its length.
  function automatic sbs_state_t begin_phase(sbs_state_t s, logic [HP_W-1:0] hp);
    sbs_state_t      t;
    logic [HP_W-1:0] len;
    t   = s;
    len = (hp == '0) ? HP_W'(1) : hp;
    unique case (t.cmd)
      CMD_START: begin
        if (t.phase == 3'd0) begin
          t.dat_drv = 1'b1;
          t.dat_lvl = 1'b1;
        end else if (t.phase == 3'd1) t.clk_lvl = 1'b1;
        else if (t.phase == 3'd2) t.dat_lvl = 1'b0;
        else t.clk_lvl = 1'b0;
      end
      CMD_STOP: begin
        if (t.phase == 3'd0) begin
          t.dat_drv = 1'b1;
          t.dat_lvl = 1'b0;
        end else if (t.phase == 3'd1) t.clk_lvl = 1'b1;
        else t.dat_lvl = 1'b1;
      end
      CMD_NOACK: begin
        if (t.phase == 3'd0) begin
          t.dat_drv = 1'b1;
          t.dat_lvl = 1'b1;
        end else if (t.phase == 3'd1) t.clk_lvl = 1'b1;
        else if (t.phase == 3'd2) t.clk_lvl = 1'b0;
        else t.dat_lvl = 1'b0;
      end
      CMD_WRITE: begin
        if (t.phase == 3'd0) begin
          t.dat_drv = 1'b1;
          t.dat_lvl = t.shift[7];
        end else if (t.phase == 3'd1) t.clk_lvl = 1'b1;
        else if (t.phase == 3'd2) begin
          t.clk_lvl = 1'b0;
          len = TAIL_TICKS;
        end else if (t.phase == 3'd3) begin
          t.dat_drv = 1'b0;
          len = RELEASE_TICKS;
        end else if (t.phase == 3'd4) begin
          t.clk_lvl = 1'b1;
          len = ACK_HIGH_TICKS;
        end else t.clk_lvl = 1'b0;
      end
      CMD_READ: begin
        if (t.phase == 3'd0) t.dat_drv = 1'b0;
        else if (t.phase == 3'd1) t.clk_lvl = 1'b1;
        else t.clk_lvl = 1'b0;
      end
      default: ;
    endcase
    t.wait_cnt = len;
    return t;
  endfunction

  sbs_state_t      s;
  logic            bp;
  logic            fin;
  logic [HP_W-1:0] w;

  always_comb begin
    s   = cur;
    bp  = 1'b0;
    fin = 1'b0;
    w   = cur.wait_cnt - HP_W'(1);
    if (cur.cmd == CMD_IDLE) begin
      if (opcode >= CMD_START && opcode <= CMD_NOACK) begin
        s.cmd     = opcode;
        s.phase   = 3'd0;
        s.bit_idx = 3'd0;
        if (opcode == CMD_WRITE) s.shift = write_data;
        else if (opcode == CMD_READ) s.shift = 8'd0;
        bp = 1'b1;
      end
    end else begin
      s.wait_cnt = w;
      if (w == '0) begin
        unique case (cur.cmd)
          CMD_START, CMD_NOACK: begin
            if (cur.phase < 3'd3) begin
              s.phase = cur.phase + 3'd1;
              bp = 1'b1;
            end else fin = 1'b1;
          end
          CMD_STOP: begin
            if (cur.phase < 3'd2) begin
              s.phase = cur.phase + 3'd1;
              bp = 1'b1;
            end else fin = 1'b1;
          end
          CMD_WRITE: begin
            if (cur.phase == 3'd2) begin
              s.shift = {cur.shift[6:0], 1'b0};
              if (cur.bit_idx < 3'd7) begin
                s.bit_idx = cur.bit_idx + 3'd1;
                s.phase   = 3'd0;
              end else s.phase = 3'd3;
              bp = 1'b1;
            end else if (cur.phase == 3'd4) begin
              s.ack   = ~sda_in;
              s.phase = cur.phase + 3'd1;
              bp = 1'b1;
            end else if (cur.phase >= 3'd5) fin = 1'b1;
            else begin
              s.phase = cur.phase + 3'd1;
              bp = 1'b1;
            end
          end
          CMD_READ: begin
            if (cur.phase == 3'd0) begin
              s.phase = 3'd1;
              bp = 1'b1;
            end else if (cur.phase == 3'd1) begin
              s.shift = {cur.shift[6:0], sda_in};
              s.phase = 3'd2;
              bp = 1'b1;
            end else if (cur.bit_idx < 3'd7) begin
              s.bit_idx = cur.bit_idx + 3'd1;
              s.phase   = 3'd1;
              bp = 1'b1;
            end else begin
              s.rd_byte = cur.shift;
              fin = 1'b1;
            end
          end
          default: fin = 1'b1;
        endcase
      end
    end
    if (bp) s = begin_phase(s, half_period);
    if (fin) begin
      s.cmd      = CMD_IDLE;
      s.phase    = 3'd0;
      s.bit_idx  = 3'd0;
      s.wait_cnt = '0;
      s.dat_drv  = 1'b1;
    end
  end

  assign nxt = s;

  always_comb begin
    res.scl       = s.clk_lvl;
    res.sda_out   = s.dat_lvl;
    res.sda_drive = s.dat_drv;
    res.busy      = (s.cmd != CMD_IDLE);
    res.done      = fin;
    res.ack_ok    = s.ack;
    res.read_data = s.rd_byte;
  end

endmodule

@@ design/sccb_master_bit_sequencer.sv @@
// Top level of the two-wire bus master bit sequencer: input register,
// sequencer state, result register. Depends on sbs_pkg, sbs_step and the assert header.
//
// Each accepted item is one bus tick and gives exactly one result item,
// which passes through the input register and the result register on
// its way to the output. One item is taken every clock cycle while the
// output is not stalled; that rate is set by the loop from the sequencer
// state register through the tick logic and back.
// half_period (cfg_wdata, reset 50) sets the length of ordinary phases
// in ticks; a value of zero counts as one tick.
`include "sccb_master_bit_sequencer_assert.svh"

module sccb_master_bit_sequencer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [sbs_pkg::HP_W-1:0]  cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                in_opcode,
  input  logic [7:0]                in_write_data,
  input  logic                      in_sda_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_scl,
  output logic                      out_sda_out,
  output logic                      out_sda_drive,
  output logic                      out_busy_res,
  output logic                      out_done_res,
  output logic                      out_ack_ok,
  output logic [7:0]                out_read_data
);
  import sbs_pkg::*;

  logic [HP_W-1:0] half_period_r;
  logic            in_vld_r;
  logic [2:0]      op_r;
  logic [7:0]      wdata_r;
  logic            sda_r;
  logic            out_vld_r;
  sbs_state_t      state_r;
  sbs_state_t      state_nxt;
  sbs_res_t        res_nxt;
  sbs_res_t        res_r;
  logic            adv;

  assign adv      = ~out_vld_r | ~out_stall;
  assign in_stall = in_vld_r & ~adv;

  sbs_step u_step (
    .cur         (state_r),
    .half_period (half_period_r),
    .opcode      (op_r),
    .write_data  (wdata_r),
    .sda_in      (sda_r),
    .nxt         (state_nxt),
    .res         (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RST;
      in_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
      state_r       <= STATE_RST;
    end else begin
      if (cfg_we) half_period_r <= cfg_wdata;
      if (!in_stall) in_vld_r <= in_valid;
      if (adv) begin
        out_vld_r <= in_vld_r;
        if (in_vld_r) state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_r    <= in_opcode;
      wdata_r <= in_write_data;
      sda_r   <= in_sda_in;
    end
    if (adv && in_vld_r) res_r <= res_nxt;
  end

  assign out_valid     = out_vld_r;
  assign out_scl       = res_r.scl;
  assign out_sda_out   = res_r.sda_out;
  assign out_sda_drive = res_r.sda_drive;
  assign out_busy_res  = res_r.busy;
  assign out_done_res  = res_r.done;
  assign out_ack_ok    = res_r.ack_ok;
  assign out_read_data = res_r.read_data;

  // A held input item must still be there in the next cycle.
  `SBS_ASSERT_NEXT(a_hold_item, clk, rst_n, in_vld_r && !adv, in_vld_r)
  // A finishing tick never reports the bus as still busy.
  `SBS_ASSERT_SAME(a_done_idle, clk, rst_n, out_vld_r && res_r.done, !res_r.busy)
  // An idle sequencer has cleared counters and drives the data line.
  `SBS_ASSERT_SAME(a_idle_clean, clk, rst_n, state_r.cmd == CMD_IDLE,
                   state_r.wait_cnt == '0 && state_r.phase == 3'd0 && state_r.dat_drv)
  // A running command always has a tick left in its phase.
  `SBS_ASSERT_SAME(a_busy_count, clk, rst_n, state_r.cmd != CMD_IDLE,
                   state_r.wait_cnt != '0)

endmodule

@@ verif/tb_sccb_master_bit_sequencer.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the two-wire bus master bit sequencer.
// Needs only sbs_pkg and the sccb_master_bit_sequencer RTL; predicts every tick in place.
module tb_sccb_master_bit_sequencer;
  import sbs_pkg::*;

  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  localparam int SDA_LOW = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_RAND = 2;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data;
    logic       sda;
  } bus_tick_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_we = 1'b0;
  logic [HP_W-1:0] cfg_wdata = '0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [2:0]      in_opcode = CMD_IDLE;
  logic [7:0]      in_write_data = 8'h00;
  logic            in_sda_in = 1'b0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic            out_scl;
  logic            out_sda_out;
  logic            out_sda_drive;
  logic            out_busy_res;
  logic            out_done_res;
  logic            out_ack_ok;
  logic [7:0]      out_read_data;

  sccb_master_bit_sequencer uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_write_data(in_write_data), .in_sda_in(in_sda_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_scl(out_scl),
    .out_sda_out(out_sda_out), .out_sda_drive(out_sda_drive),
    .out_busy_res(out_busy_res), .out_done_res(out_done_res),
    .out_ack_ok(out_ack_ok), .out_read_data(out_read_data)
  );

  always #5 clk = ~clk;

  bus_tick_t ticks_to_send[$];
  sbs_res_t  pending_lines[$];
  bus_tick_t next_tick;
  sbs_res_t  seen_lines;
  sbs_res_t  want_lines;
  logic      in_took = 1'b0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  int        mismatches = 0;
  int        ticks_checked = 0;
  int        settings_used = 0;
  int        commands_begun = 0;
  int        commands_ended = 0;
  int        acks_low = 0;
  int        acks_high = 0;
  logic [HP_W-1:0] plan_hp = HALF_PERIOD_RST;

  // Mirror of the sequencer state.
  logic [HP_W-1:0] hp_model;
  logic [2:0]      seq_cmd;
  logic [3:0]      seq_phase;
  logic [3:0]      seq_bit;
  logic [HP_W-1:0] seq_wait;
  logic [7:0]      seq_shift;
  logic            line_scl, line_sda, line_drive;
  logic            ack_seen, tick_done;
  logic [7:0]      byte_read;

  function automatic void clear_sequencer();
    hp_model = HALF_PERIOD_RST;
    seq_cmd = CMD_IDLE;
    seq_phase = '0;
    seq_bit = '0;
    seq_wait = '0;
    seq_shift = '0;
    line_scl = 1'b1;
    line_sda = 1'b1;
    line_drive = 1'b1;
    ack_seen = 1'b0;
    byte_read = '0;
  endfunction

  // Sets the lines for the phase just entered and loads its length.
  function automatic void enter_phase();
    logic [HP_W-1:0] span;
    span = (hp_model == '0) ? 10'd1 : hp_model;
    unique case (seq_cmd)
      CMD_START: begin
        if (seq_phase == 0) begin
          line_drive = 1'b1;
          line_sda = 1'b1;
        end else if (seq_phase == 1) line_scl = 1'b1;
        else if (seq_phase == 2) line_sda = 1'b0;
        else line_scl = 1'b0;
      end
      CMD_STOP: begin
        if (seq_phase == 0) begin
          line_drive = 1'b1;
          line_sda = 1'b0;
        end else if (seq_phase == 1) line_scl = 1'b1;
        else line_sda = 1'b1;
      end
      CMD_NOACK: begin
        if (seq_phase == 0) begin
          line_drive = 1'b1;
          line_sda = 1'b1;
        end else if (seq_phase == 1) line_scl = 1'b1;
        else if (seq_phase == 2) line_scl = 1'b0;
        else line_sda = 1'b0;
      end
      CMD_WRITE: begin
        if (seq_phase == 0) begin
          line_drive = 1'b1;
          line_sda = seq_shift[7];
        end else if (seq_phase == 1) line_scl = 1'b1;
        else if (seq_phase == 2) begin
          line_scl = 1'b0;
          span = TAIL_TICKS;
        end else if (seq_phase == 3) begin
          line_drive = 1'b0;
          span = RELEASE_TICKS;
        end else if (seq_phase == 4) begin
          line_scl = 1'b1;
          span = ACK_HIGH_TICKS;
        end else line_scl = 1'b0;
      end
      CMD_READ: begin
        if (seq_phase == 0) line_drive = 1'b0;
        else if (seq_phase == 1) line_scl = 1'b1;
        else line_scl = 1'b0;
      end
      default: ;
    endcase
    seq_wait = span;
  endfunction

  function automatic void step_phase();
    seq_phase = seq_phase + 4'd1;
    enter_phase();
  endfunction

  function automatic void close_command();
    seq_cmd = CMD_IDLE;
    seq_phase = '0;
    seq_bit = '0;
    seq_wait = '0;
    line_drive = 1'b1;
    tick_done = 1'b1;
  endfunction

  function automatic void leave_phase(logic sda);
    unique case (seq_cmd)
      CMD_START, CMD_NOACK: begin
        if (seq_phase < 3) step_phase();
        else close_command();
      end
      CMD_STOP: begin
        if (seq_phase < 2) step_phase();
        else close_command();
      end
      CMD_WRITE: begin
        if (seq_phase == 2) begin
          seq_shift = {seq_shift[6:0], 1'b0};
          if (seq_bit < 7) begin
            seq_bit = seq_bit + 4'd1;
            seq_phase = '0;
          end else seq_phase = 4'd3;
          enter_phase();
        end else if (seq_phase == 4) begin
          ack_seen = ~sda;
          if (sda) acks_high++;
          else acks_low++;
          step_phase();
        end else if (seq_phase >= 5) close_command();
        else step_phase();
      end
      CMD_READ: begin
        if (seq_phase == 0) step_phase();
        else if (seq_phase == 1) begin
          seq_shift = {seq_shift[6:0], sda};
          step_phase();
        end else if (seq_bit < 7) begin
          seq_bit = seq_bit + 4'd1;
          seq_phase = 4'd1;
          enter_phase();
        end else begin
          byte_read = seq_shift;
          close_command();
        end
      end
      default: close_command();
    endcase
  endfunction

  // Advances the mirror by one bus tick and returns the line levels after it.
  function automatic sbs_res_t bus_tick(logic [2:0] op, logic [7:0] data, logic sda);
    sbs_res_t lines;
    tick_done = 1'b0;
    if (seq_cmd == CMD_IDLE) begin
      if (op >= CMD_START && op <= CMD_NOACK) begin
        seq_cmd = op;
        seq_phase = '0;
        seq_bit = '0;
        if (op == CMD_WRITE) seq_shift = data;
        else if (op == CMD_READ) seq_shift = '0;
        enter_phase();
        commands_begun++;
      end
    end else begin
      seq_wait = seq_wait - 10'd1;
      if (seq_wait == '0) leave_phase(sda);
    end
    if (tick_done) commands_ended++;
    lines.scl = line_scl;
    lines.sda_out = line_sda;
    lines.sda_drive = line_drive;
    lines.busy = (seq_cmd != CMD_IDLE);
    lines.done = tick_done;
    lines.ack_ok = ack_seen;
    lines.read_data = byte_read;
    return lines;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Checks results and predicts each accepted item.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_sequencer();
      in_took <= 1'b0;
    end else begin
      if (cfg_we) hp_model = cfg_wdata;
      if (out_valid && !out_stall) begin
        seen_lines.scl = out_scl;
        seen_lines.sda_out = out_sda_out;
        seen_lines.sda_drive = out_sda_drive;
        seen_lines.busy = out_busy_res;
        seen_lines.done = out_done_res;
        seen_lines.ack_ok = out_ack_ok;
        seen_lines.read_data = out_read_data;
        if (pending_lines.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, seen_lines);
          mismatches++;
        end else begin
          want_lines = pending_lines.pop_front();
          check_field("scl", 8'(want_lines.scl), 8'(seen_lines.scl));
          check_field("sda_out", 8'(want_lines.sda_out), 8'(seen_lines.sda_out));
          check_field("sda_drive", 8'(want_lines.sda_drive), 8'(seen_lines.sda_drive));
          check_field("busy", 8'(want_lines.busy), 8'(seen_lines.busy));
          check_field("done", 8'(want_lines.done), 8'(seen_lines.done));
          check_field("ack_ok", 8'(want_lines.ack_ok), 8'(seen_lines.ack_ok));
          check_field("read_data", want_lines.read_data, seen_lines.read_data);
          ticks_checked++;
        end
      end
      if (in_valid && !in_stall)
        pending_lines.push_back(bus_tick(in_opcode, in_write_data, in_sda_in));
      in_took <= in_valid && !in_stall;
    end
  end

  // Sender and receiver both act on the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (ticks_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_tick = ticks_to_send.pop_front();
        in_opcode <= next_tick.op;
        in_write_data <= next_tick.data;
        in_sda_in <= next_tick.sda;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  function automatic int cmd_ticks(logic [2:0] op);
    int h;
    h = (plan_hp == '0) ? 1 : int'(plan_hp);
    unique case (op)
      CMD_START, CMD_NOACK: return 4 * h;
      CMD_STOP: return 3 * h;
      CMD_WRITE: return 8 * (2 * h + int'(TAIL_TICKS)) + int'(RELEASE_TICKS)
                        + int'(ACK_HIGH_TICKS) + h;
      CMD_READ: return 17 * h;
      default: return 0;
    endcase
  endfunction

  function automatic logic pick_sda(int mode);
    if (mode == SDA_RAND) return 1'($urandom_range(1));
    return (mode == SDA_HIGH);
  endfunction

  // Queues a command item and the given number of tick items behind it.
  task automatic issue_cmd(logic [2:0] op, logic [7:0] data, int mode, int fill, bit noisy);
    bus_tick_t t;
    t.op = op;
    t.data = data;
    t.sda = pick_sda(mode);
    ticks_to_send.push_back(t);
    repeat (fill) begin
      t.op = (noisy && $urandom_range(7) == 0) ? 3'($urandom_range(7)) : CMD_IDLE;
      t.data = 8'($urandom);
      t.sda = pick_sda(mode);
      ticks_to_send.push_back(t);
    end
  endtask

  task automatic issue_full(logic [2:0] op, logic [7:0] data, int mode);
    issue_cmd(op, data, mode, cmd_ticks(op) + 1, 1'b0);
  endtask

  task automatic drain_bus();
    while (ticks_to_send.size() != 0 || in_valid || pending_lines.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_half_period(logic [HP_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    plan_hp = value;
    settings_used++;
  endtask

  // Mostly complete commands with random data; some are cut short so the next
  // command lands while busy, and some items carry no command at all.
  task automatic random_traffic(int budget);
    int sent;
    int pick;
    int fill;
    int mode;
    logic [2:0] op;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(15);
      if (pick < 13) op = 3'($urandom_range(CMD_NOACK, CMD_START));
      else if (pick == 13) op = CMD_IDLE;
      else op = 3'($urandom_range(OP_RSVD7, OP_RSVD6));
      fill = cmd_ticks(op) + $urandom_range(3);
      if ($urandom_range(7) == 0) fill = $urandom_range(cmd_ticks(op));
      mode = ($urandom_range(5) < 4) ? SDA_RAND : $urandom_range(1);
      issue_cmd(op, 8'($urandom), mode, fill, 1'b1);
      sent += fill + 1;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset half period.
    settings_used = 1;
    issue_full(CMD_STOP, 8'h00, SDA_RAND);
    drain_bus();

    // Directed commands at the shortest phase with a mostly idle sender.
    set_half_period(10'd1);
    send_idle_pct = 63;
    stall_pct = 0;
    issue_full(CMD_START, 8'h00, SDA_RAND);
    issue_full(CMD_WRITE, 8'hA5, SDA_LOW);
    issue_full(CMD_WRITE, 8'h5A, SDA_HIGH);
    issue_full(CMD_READ, 8'h00, SDA_HIGH);
    issue_full(CMD_READ, 8'h00, SDA_LOW);
    issue_full(CMD_READ, 8'h00, SDA_RAND);
    issue_full(CMD_NOACK, 8'h00, SDA_RAND);
    issue_full(CMD_STOP, 8'h00, SDA_RAND);
    issue_cmd(OP_RSVD6, 8'h12, SDA_RAND, 1, 1'b0);
    issue_cmd(OP_RSVD7, 8'h34, SDA_RAND, 1, 1'b0);
    issue_cmd(CMD_IDLE, 8'h56, SDA_RAND, 1, 1'b0);
    // The write arrives while the start is still running and must be dropped.
    issue_cmd(CMD_START, 8'h00, SDA_RAND, 1, 1'b0);
    issue_cmd(CMD_WRITE, 8'h3C, SDA_RAND, cmd_ticks(CMD_START), 1'b0);
    issue_full(CMD_STOP, 8'h00, SDA_RAND);
    drain_bus();

    set_half_period(10'd0);
    send_idle_pct = 0;
    stall_pct = 0;
    random_traffic(80);
    drain_bus();

    set_half_period(10'd2);
    send_idle_pct = 0;
    stall_pct = 63;
    random_traffic(80);
    drain_bus();

    set_half_period(10'd3);
    send_idle_pct = 15;
    stall_pct = 15;
    random_traffic(80);
    drain_bus();

    // The longest phase: only the first ticks of a start are checked.
    set_half_period(10'd1023);
    send_idle_pct = 0;
    stall_pct = 0;
    issue_cmd(CMD_START, 8'h00, SDA_RAND, 20, 1'b1);
    drain_bus();

    $display("Checked %0d bus ticks under %0d half-period settings;", ticks_checked,
             settings_used);
    $display("%0d commands began, %0d ended; write acks seen: %0d low, %0d high.",
             commands_begun, commands_ended, acks_low, acks_high);
    if (mismatches == 0 && pending_lines.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Timed out with %0d ticks still unchecked.", pending_lines.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/sbs_pkg.sv
design/sbs_step.sv
design/sccb_master_bit_sequencer.sv
verif/tb_sccb_master_bit_sequencer.sv
